[hw/rtl/assert_macros.svh]
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

[hw/rtl/ffha_pkg.sv]
// shared types and constants of the first-fit heap allocator
// no dependencies
package ffha_pkg;

  localparam int GranuleShift = 3;
  localparam int GranuleBytes = 1 << GranuleShift;
  localparam int TypeW  = 2;
  localparam int SizeW  = 14;
  localparam int AddrW  = 13;
  localparam int CfgW   = 11;
  localparam int StatW  = 2;
  localparam int NeedW  = 12;
  localparam int WideW  = 18;

  localparam logic [TypeW-1:0] ReqAlloc = 2'd0;
  localparam logic [TypeW-1:0] ReqFree  = 2'd1;
  localparam logic [TypeW-1:0] ReqQuery = 2'd2;

  localparam logic [StatW-1:0] StatOk      = 2'd0;
  localparam logic [StatW-1:0] StatNoFit   = 2'd1;
  localparam logic [StatW-1:0] StatBadAddr = 2'd2;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_LOC,
    ST_WALK,
    ST_A_SPLIT,
    ST_A_LINK,
    ST_F_NODE,
    ST_F_PREV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic len;
    logic link;
    logic mark;
  } store_we_t;

endpackage

[hw/rtl/first_fit_heap_allocator.sv]
// alloc walks the free list to the first block that fits, splitting it if larger; free walks
// the free blocks below it, then merges; a size query reads the block; one item at a time.
// the free list is walked one node per cycle through the single read port of the store.
// after reset and after each arena size write a clearing pass over all ARENA_DEPTH entries
// rebuilds the arena as one free block; no request is taken during it.
module first_fit_heap_allocator #(
  parameter int ARENA_DEPTH = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ffha_pkg::CfgW-1:0]    cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ffha_pkg::TypeW-1:0]   req_type_i,
  input  logic [ffha_pkg::SizeW-1:0]   request_size_i,
  input  logic [ffha_pkg::AddrW-1:0]   block_address_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ffha_pkg::AddrW-1:0]   result_address_o,
  output logic [ffha_pkg::SizeW-1:0]   result_size_o,
  output logic [ffha_pkg::StatW-1:0]   status_o
);
  import ffha_pkg::*;

  localparam int Aw = $clog2(ARENA_DEPTH);
  localparam int Lw = $clog2(ARENA_DEPTH + 1);
  localparam logic [WideW-1:0] DepthW = WideW'(ARENA_DEPTH);
  localparam logic [Aw-1:0] LastIdx = Aw'(ARENA_DEPTH - 1);

  state_e state_q, state_d;
  logic [Lw-1:0]    arena_q, arena_d;
  logic [Lw-1:0]    head_q, head_d;
  logic [Aw-1:0]    clr_q, clr_d;
  logic [TypeW-1:0] kind_q, kind_d;
  logic [NeedW-1:0] need_q, need_d;
  logic [Lw-1:0]    cur_q, cur_d;
  logic [Aw-1:0]    prev_q, prev_d;
  logic             prev_vld_q, prev_vld_d;
  logic [Lw-1:0]    prev_len_q, prev_len_d;
  logic [Lw-1:0]    steps_q, steps_d;
  logic [Aw-1:0]    g_q, g_d;
  logic             loc_ok_q, loc_ok_d;
  logic [Lw-1:0]    len_q, len_d;
  logic [Lw-1:0]    link_q, link_d;
  logic [Lw-1:0]    len_g_q, len_g_d;
  logic [Lw-1:0]    follow_q, follow_d;
  logic [AddrW-1:0] res_addr_q, res_addr_d;
  logic [SizeW-1:0] res_size_q, res_size_d;
  logic [StatW-1:0] res_stat_q, res_stat_d;
  logic             out_valid_q, out_valid_d;
  logic [AddrW-1:0] out_addr_q, out_addr_d;
  logic [SizeW-1:0] out_size_q, out_size_d;
  logic [StatW-1:0] out_stat_q, out_stat_d;

  store_we_t     we;
  logic [Aw-1:0] len_waddr, link_waddr, mark_waddr, raddr;
  logic [Lw-1:0] len_wdata, link_wdata, len_rd, link_rd;
  logic          mark_wdata, mark_rd;

  logic [WideW-1:0] cfg_w, q_w, cur_w, split_at, need_w;
  logic             cur_ok, node_ok, merge_next, merge_prev;
  logic [Lw-1:0]    new_len_g, new_link_g;

  ffha_store #(
    .Depth(ARENA_DEPTH),
    .Aw   (Aw),
    .Lw   (Lw)
  ) u_store (
    .clk_i       (clk_i),
    .we_i        (we),
    .len_waddr_i (len_waddr),
    .len_wdata_i (len_wdata),
    .link_waddr_i(link_waddr),
    .link_wdata_i(link_wdata),
    .mark_waddr_i(mark_waddr),
    .mark_wdata_i(mark_wdata),
    .raddr_i     (raddr),
    .len_rdata_o (len_rd),
    .link_rdata_o(link_rd),
    .mark_rdata_o(mark_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      arena_q     <= Lw'(ARENA_DEPTH);
      head_q      <= '0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      arena_q     <= arena_d;
      head_q      <= head_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    need_q     <= need_d;
    cur_q      <= cur_d;
    prev_q     <= prev_d;
    prev_vld_q <= prev_vld_d;
    prev_len_q <= prev_len_d;
    steps_q    <= steps_d;
    g_q        <= g_d;
    loc_ok_q   <= loc_ok_d;
    len_q      <= len_d;
    link_q     <= link_d;
    len_g_q    <= len_g_d;
    follow_q   <= follow_d;
    res_addr_q <= res_addr_d;
    res_size_q <= res_size_d;
    res_stat_q <= res_stat_d;
    out_addr_q <= out_addr_d;
    out_size_q <= out_size_d;
    out_stat_q <= out_stat_d;
  end

  // shared compare and add paths
  always_comb begin
    cfg_w    = WideW'(cfg_wdata_i);
    q_w      = WideW'(block_address_i >> GranuleShift) - WideW'(1);
    need_w   = WideW'(need_q);
    cur_w    = WideW'(cur_q);
    split_at = cur_w + need_w;
    cur_ok   = (cur_w < WideW'(arena_q)) && (cur_w < DepthW);
    node_ok  = cur_ok && (WideW'(steps_q) < DepthW);
    merge_next = cur_ok && (WideW'(g_q) + WideW'(len_g_q) == cur_w);
    new_len_g  = merge_next ? Lw'(WideW'(len_g_q) + WideW'(len_q)) : len_g_q;
    new_link_g = merge_next ? link_q : cur_q;
    merge_prev = prev_vld_q && (WideW'(prev_q) + WideW'(prev_len_q) == WideW'(g_q));
  end

  always_comb begin
    state_d     = state_q;
    arena_d     = arena_q;
    head_d      = head_q;
    clr_d       = clr_q;
    kind_d      = kind_q;
    need_d      = need_q;
    cur_d       = cur_q;
    prev_d      = prev_q;
    prev_vld_d  = prev_vld_q;
    prev_len_d  = prev_len_q;
    steps_d     = steps_q;
    g_d         = g_q;
    loc_ok_d    = loc_ok_q;
    len_d       = len_q;
    link_d      = link_q;
    len_g_d     = len_g_q;
    follow_d    = follow_q;
    res_addr_d  = res_addr_q;
    res_size_d  = res_size_q;
    res_stat_d  = res_stat_q;
    out_valid_d = out_valid_q;
    out_addr_d  = out_addr_q;
    out_size_d  = out_size_q;
    out_stat_d  = out_stat_q;
    we          = '0;
    len_waddr   = '0;
    len_wdata   = '0;
    link_waddr  = '0;
    link_wdata  = '0;
    mark_waddr  = '0;
    mark_wdata  = 1'b0;
    raddr       = head_q[Aw-1:0];
    in_stall_o  = 1'b1;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLR: begin
        we.mark    = 1'b1;
        mark_waddr = clr_q;
        if (clr_q == '0) begin
          we.len     = 1'b1;
          we.link    = 1'b1;
          len_wdata  = arena_q;
          link_wdata = arena_q;
        end
        clr_d = clr_q + Aw'(1);
        if (clr_q == LastIdx) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (req_type_i != ReqAlloc) begin
          raddr = q_w[Aw-1:0];
        end
        if (in_valid_i) begin
          kind_d     = req_type_i;
          need_d     = NeedW'(((WideW'(request_size_i) + WideW'(GranuleBytes - 1))
                              >> GranuleShift) + WideW'(1));
          g_d        = q_w[Aw-1:0];
          loc_ok_d   = (block_address_i != '0) && (block_address_i[GranuleShift-1:0] == '0)
                       && (q_w < WideW'(arena_q)) && (q_w < DepthW);
          cur_d      = head_q;
          prev_vld_d = 1'b0;
          steps_d    = '0;
          res_addr_d = '0;
          res_size_d = '0;
          res_stat_d = StatOk;
          priority if (req_type_i == ReqAlloc) begin
            if (request_size_i == '0) begin
              res_stat_d = StatNoFit;
              state_d    = ST_DONE;
            end else begin
              state_d = ST_WALK;
            end
          end else if (req_type_i == ReqFree || req_type_i == ReqQuery) begin
            state_d = ST_LOC;
          end else begin
            res_stat_d = StatNoFit;
            state_d    = ST_DONE;
          end
        end
      end
      ST_LOC: begin
        if (!loc_ok_q || !mark_rd) begin
          res_stat_d = StatBadAddr;
          state_d    = ST_DONE;
        end else if (kind_q == ReqQuery) begin
          res_size_d = SizeW'((WideW'(len_rd) - WideW'(1)) << GranuleShift);
          state_d    = ST_DONE;
        end else begin
          len_g_d = len_rd;
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (kind_q == ReqAlloc) begin
          if (!node_ok) begin
            res_stat_d = StatNoFit;
            state_d    = ST_DONE;
          end else if (WideW'(len_rd) >= need_w) begin
            len_d  = len_rd;
            link_d = link_rd;
            if (WideW'(len_rd) == need_w) begin
              follow_d = link_rd;
              state_d  = ST_A_LINK;
            end else if (split_at >= DepthW) begin
              res_stat_d = StatNoFit;
              state_d    = ST_DONE;
            end else begin
              follow_d = Lw'(split_at);
              state_d  = ST_A_SPLIT;
            end
          end else begin
            prev_d     = cur_q[Aw-1:0];
            prev_vld_d = 1'b1;
            cur_d      = link_rd;
            steps_d    = steps_q + Lw'(1);
            raddr      = link_rd[Aw-1:0];
          end
        end else begin
          // free: stop at the first free block at or above the freed one
          if (node_ok && (cur_w < WideW'(g_q))) begin
            prev_d     = cur_q[Aw-1:0];
            prev_vld_d = 1'b1;
            prev_len_d = len_rd;
            cur_d      = link_rd;
            steps_d    = steps_q + Lw'(1);
            raddr      = link_rd[Aw-1:0];
          end else begin
            len_d   = len_rd;
            link_d  = link_rd;
            state_d = ST_F_NODE;
          end
        end
      end
      ST_A_SPLIT: begin
        we.len     = 1'b1;
        we.link    = 1'b1;
        we.mark    = 1'b1;
        len_waddr  = follow_q[Aw-1:0];
        link_waddr = follow_q[Aw-1:0];
        mark_waddr = follow_q[Aw-1:0];
        len_wdata  = Lw'(WideW'(len_q) - need_w);
        link_wdata = link_q;
        mark_wdata = 1'b0;
        state_d    = ST_A_LINK;
      end
      ST_A_LINK: begin
        we.len     = 1'b1;
        we.mark    = 1'b1;
        len_waddr  = cur_q[Aw-1:0];
        mark_waddr = cur_q[Aw-1:0];
        len_wdata  = Lw'(need_q);
        mark_wdata = 1'b1;
        if (prev_vld_q) begin
          we.link    = 1'b1;
          link_waddr = prev_q;
          link_wdata = follow_q;
        end else begin
          head_d = follow_q;
        end
        res_addr_d = AddrW'((cur_w + WideW'(1)) << GranuleShift);
        res_size_d = SizeW'((need_w - WideW'(1)) << GranuleShift);
        state_d    = ST_DONE;
      end
      ST_F_NODE: begin
        we.len     = 1'b1;
        we.link    = 1'b1;
        we.mark    = 1'b1;
        len_waddr  = g_q;
        link_waddr = g_q;
        mark_waddr = g_q;
        len_wdata  = new_len_g;
        link_wdata = new_link_g;
        mark_wdata = 1'b0;
        len_g_d    = new_len_g;
        link_d     = new_link_g;
        state_d    = ST_F_PREV;
      end
      ST_F_PREV: begin
        if (prev_vld_q) begin
          we.link    = 1'b1;
          link_waddr = prev_q;
          link_wdata = merge_prev ? link_q : Lw'(g_q);
          if (merge_prev) begin
            we.len    = 1'b1;
            len_waddr = prev_q;
            len_wdata = Lw'(WideW'(prev_len_q) + WideW'(len_g_q));
          end
        end else begin
          head_d = Lw'(g_q);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_addr_d  = res_addr_q;
          out_size_d  = res_size_q;
          out_stat_d  = res_stat_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLR;
        clr_d   = '0;
      end
    endcase

    // arena size write rebuilds the arena
    if (cfg_we_i) begin
      priority if (cfg_w < WideW'(2)) begin
        arena_d = Lw'(2);
      end else if (cfg_w > DepthW) begin
        arena_d = Lw'(ARENA_DEPTH);
      end else begin
        arena_d = Lw'(cfg_w);
      end
      head_d  = '0;
      clr_d   = '0;
      state_d = ST_CLR;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_address_o = out_addr_q;
  assign result_size_o    = out_size_q;
  assign status_o         = out_stat_q;

endmodule

[hw/rtl/ffha_store.sv]
// block length, free link and allocated mark memories of the allocator
// depends on ffha_pkg
module ffha_store #(
  parameter int Depth = 1024,
  parameter int Aw    = 10,
  parameter int Lw    = 11
) (
  input  logic                clk_i,
  input  ffha_pkg::store_we_t we_i,
  input  logic [Aw-1:0]       len_waddr_i,
  input  logic [Lw-1:0]       len_wdata_i,
  input  logic [Aw-1:0]       link_waddr_i,
  input  logic [Lw-1:0]       link_wdata_i,
  input  logic [Aw-1:0]       mark_waddr_i,
  input  logic                mark_wdata_i,
  input  logic [Aw-1:0]       raddr_i,
  output logic [Lw-1:0]       len_rdata_o,
  output logic [Lw-1:0]       link_rdata_o,
  output logic                mark_rdata_o
);
  import ffha_pkg::*;

  logic [Lw-1:0] len_mem  [Depth];
  logic [Lw-1:0] link_mem [Depth];
  logic          mark_mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i.len) begin
      len_mem[len_waddr_i] <= len_wdata_i;
    end
    if (we_i.link) begin
      link_mem[link_waddr_i] <= link_wdata_i;
    end
    if (we_i.mark) begin
      mark_mem[mark_waddr_i] <= mark_wdata_i;
    end
    len_rdata_o  <= len_mem[raddr_i];
    link_rdata_o <= link_mem[raddr_i];
    mark_rdata_o <= mark_mem[raddr_i];
  end

endmodule

[hw/rtl/ffha_checker.sv]
// port-level checks of the first-fit heap allocator and their bind
// depends on ffha_pkg and assert_macros.svh
`include "assert_macros.svh"
module ffha_port_checks (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       out_valid_i,
  input logic                       out_stall_i,
  input logic [ffha_pkg::AddrW-1:0] result_address_i,
  input logic [ffha_pkg::SizeW-1:0] result_size_i,
  input logic [ffha_pkg::StatW-1:0] status_i
);
  import ffha_pkg::*;

  `ASSERT_CLK(a_valid_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=> out_valid_i,
              "result word dropped while stalled")
  `ASSERT_CLK(a_word_hold, clk_i, rst_ni, out_valid_i && out_stall_i |=>
              $stable(result_address_i) && $stable(result_size_i) && $stable(status_i),
              "stalled result word changed")
  `ASSERT_NEVER(a_status_code, clk_i, rst_ni, out_valid_i && status_i != StatOk &&
                status_i != StatNoFit && status_i != StatBadAddr, "unknown status code")
  `ASSERT_NEVER(a_fail_zero, clk_i, rst_ni, out_valid_i && status_i != StatOk &&
                (result_address_i != '0 || result_size_i != '0),
                "failed request carries address or size")
  `ASSERT_NEVER(a_size_granule, clk_i, rst_ni,
                out_valid_i && result_size_i[GranuleShift-1:0] != '0,
                "size not a whole number of granules")

endmodule

bind first_fit_heap_allocator ffha_port_checks u_ffha_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .result_address_i(result_address_o),
  .result_size_i   (result_size_o),
  .status_i        (status_o)
);
